// ===== src/slebc_pkg.sv =====
// Package for the serial line echo buffer core.
// Holds the character codes, the queue item type and the back-end state codes.
// No dependencies.
package slebc_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef struct packed {
        logic       is_term;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_if_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LF1  = 4'b0010,
        S_DATA = 4'b0100,
        S_LF2  = 4'b1000
    } state_t;

endpackage

// ===== src/slebc_front.sv =====
// Front end of the serial line echo buffer core: accepts received bytes,
// tags line terminators and holds them in a two-item queue.
// Depends on slebc_pkg.
module slebc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    output slebc_pkg::q_if_t    q,
    input  logic                pop
);

    slebc_pkg::cmd_t                  q_mem [slebc_pkg::QDEPTH];
    logic [slebc_pkg::QAW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [slebc_pkg::QAW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [slebc_pkg::QAW:0]          count_reg, count_next;
    logic                             push;
    logic                             do_pop;
    slebc_pkg::cmd_t                  new_cmd;

    assign in_stall = (count_reg == (slebc_pkg::QAW+1)'(slebc_pkg::QDEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    assign q.valid  = (count_reg != '0);
    assign q.cmd    = q_mem[rd_ptr_reg];

    always_comb
    begin
        new_cmd.data    = rx_byte;
        new_cmd.is_term = (rx_byte == slebc_pkg::CH_CR) || (rx_byte == slebc_pkg::CH_LF);

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == slebc_pkg::QAW'(slebc_pkg::QDEPTH-1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == slebc_pkg::QAW'(slebc_pkg::QDEPTH-1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (slebc_pkg::QAW+1)'(slebc_pkg::QDEPTH))
        else $error("queue count above depth");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !do_pop) |=> in_stall)
        else $error("queue left full state without a pop");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not reduce the count");

endmodule

// ===== src/slebc_back.sv =====
// Back end of the serial line echo buffer core: line store, fill position,
// echo and replay sequencer, output register.
// Depends on slebc_pkg.
module slebc_back
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  slebc_pkg::q_if_t    q,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          tx_byte,
    output logic                run_last
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [AW-1:0] LAST_POS = AW'(LINE_CAPACITY - 1);

    logic [7:0]           line_mem [LINE_CAPACITY];
    slebc_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;
    logic [7:0]           rd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           tx_byte_reg;
    logic                 run_last_reg;
    logic                 out_free;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 load;
    logic [7:0]           load_byte;
    logic                 load_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign run_last  = run_last_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        pop         = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = fill_reg;
        wr_data     = q.cmd.data;
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg;
        load        = 1'b0;
        load_byte   = slebc_pkg::CH_CR;
        load_last   = 1'b0;

        unique case (state_reg)
            slebc_pkg::S_IDLE:
            begin
                if (q.valid && out_free)
                begin
                    pop   = 1'b1;
                    wr_en = 1'b1;
                    load  = 1'b1;
                    if (q.cmd.is_term)
                    begin
                        wr_data     = slebc_pkg::CH_NUL;
                        load_byte   = slebc_pkg::CH_CR;
                        fill_next   = '0;
                        rd_idx_next = '0;
                        state_next  = slebc_pkg::S_LF1;
                    end
                    else
                    begin
                        load_byte = q.cmd.data;
                        load_last = 1'b1;
                        if (fill_reg != LAST_POS)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
            end
            slebc_pkg::S_LF1:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_byte  = slebc_pkg::CH_LF;
                    rd_en      = 1'b1;
                    state_next = slebc_pkg::S_DATA;
                end
            end
            slebc_pkg::S_DATA:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (rd_data_reg == slebc_pkg::CH_NUL)
                    begin
                        load_byte  = slebc_pkg::CH_CR;
                        state_next = slebc_pkg::S_LF2;
                    end
                    else
                    begin
                        load_byte   = rd_data_reg;
                        rd_idx_next = rd_idx_reg + 1'b1;
                        rd_addr     = rd_idx_reg + 1'b1;
                        rd_en       = 1'b1;
                    end
                end
            end
            slebc_pkg::S_LF2:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_byte  = slebc_pkg::CH_LF;
                    load_last  = 1'b1;
                    state_next = slebc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slebc_pkg::S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slebc_pkg::S_IDLE;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg  <= load_byte;
            run_last_reg <= load_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LAST_POS)
        else $error("fill position beyond last slot");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == slebc_pkg::S_IDLE) && q.valid && out_free)
        else $error("queue popped outside idle");

    a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q.cmd.is_term) |=> (fill_reg == '0) && (state_reg == slebc_pkg::S_LF1))
        else $error("terminator did not clear the line");

    a_replay_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == slebc_pkg::S_DATA) && out_free && (rd_data_reg == slebc_pkg::CH_NUL))
        |=> (tx_byte_reg == slebc_pkg::CH_CR) && !run_last_reg
            && (state_reg == slebc_pkg::S_LF2))
        else $error("replay end did not emit CR");

    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == slebc_pkg::S_LF2) && out_free)
        |=> run_last_reg && out_valid_reg && (state_reg == slebc_pkg::S_IDLE))
        else $error("final LF not marked last");

endmodule

// ===== src/serial_line_echo_buffer_core.sv =====
// Serial line echo buffer core: top level.
// Depends on slebc_pkg, slebc_front and slebc_back.
//
// Input channel (in_valid, in_stall, rx_byte) takes one received byte per item.
// Output channel (out_valid, out_stall, tx_byte, run_last) gives the bytes to
// transmit; run_last marks the final output item caused by one input item.
// A byte other than CR or LF is stored in the line and echoed: one output item.
// CR or LF gives CR LF, the stored line up to its first zero byte, CR LF:
// n+4 output items for n replayed bytes, n at most LINE_CAPACITY-1.
// A two-item queue decouples the front end from the sequencer, so input items
// are taken while a line is being replayed until the queue fills.
// The accepted input item is held in the queue and then loaded into the output register.
// Throughput: the sequencer issues one output item per cycle, while out_stall
// does not hold it, from the line store's single registered read port.
// While out_stall is high the output register holds and the sequencer waits.
// Reset clears the queue, the fill position and the output valid; the line
// store needs no clearing as a line is only read after it is written.
module serial_line_echo_buffer_core
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        run_last
);

    slebc_pkg::q_if_t q;
    logic             pop;

    slebc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q        (q),
        .pop      (pop)
    );

    slebc_back
    #(
        .LINE_CAPACITY (LINE_CAPACITY)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_byte   (tx_byte),
        .run_last  (run_last)
    );

endmodule

// ===== tb/sv/serial_line_echo_buffer_core_test.sv =====
// Testbench for serial_line_echo_buffer_core: random and directed received bytes,
// with a line echo predictor and an in-order check of every transmitted byte.
// Depends on slebc_pkg and the core RTL.
module serial_line_echo_buffer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_CAP = 32;
    localparam int RANDOM_ITEMS = 460;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_item_t;

    class echo_scoreboard;
        logic [7:0]  line_buf [LINE_CAP];
        int unsigned fill = 0;
        tx_item_t    tx_due_q [$];
        int          errors = 0;

        function void push_tx(logic [7:0] d, logic last);
            tx_item_t t;
            t.data = d;
            t.last = last;
            tx_due_q.push_back(t);
        endfunction

        function void take_rx(logic [7:0] b);
            int unsigned pos;
            int unsigned i;
            pos = fill;
            if (b == slebc_pkg::CH_CR || b == slebc_pkg::CH_LF)
            begin
                line_buf[pos] = slebc_pkg::CH_NUL;
                push_tx(slebc_pkg::CH_CR, 1'b0);
                push_tx(slebc_pkg::CH_LF, 1'b0);
                for (i = 0; i < pos; i++)
                begin
                    if (line_buf[i] == slebc_pkg::CH_NUL)
                        break;
                    push_tx(line_buf[i], 1'b0);
                end
                push_tx(slebc_pkg::CH_CR, 1'b0);
                push_tx(slebc_pkg::CH_LF, 1'b1);
                fill = 0;
            end
            else
            begin
                line_buf[pos] = b;
                push_tx(b, 1'b1);
                if (pos < LINE_CAP - 1)
                    pos++;
                fill = pos;
            end
        endfunction

        function void match_tx(logic [7:0] d, logic last);
            tx_item_t t;
            if (tx_due_q.size() == 0)
            begin
                $display("%0t: unexpected item tx_byte=%h run_last=%b", $time, d, last);
                errors++;
            end
            else
            begin
                t = tx_due_q.pop_front();
                if (d !== t.data)
                begin
                    $display("%0t: tx_byte expected %h actual %h", $time, t.data, d);
                    errors++;
                end
                if (last !== t.last)
                begin
                    $display("%0t: run_last expected %b actual %b", $time, t.last, last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return tx_due_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] tx_byte;
    logic       run_last;

    echo_scoreboard sb = new;
    int             sent = 0;

    serial_line_echo_buffer_core #(.LINE_CAPACITY(LINE_CAP)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_byte   (tx_byte),
        .run_last  (run_last)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic send_byte(input logic [7:0] b, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_rx(b);
        sent++;
    endtask

    // receiver side
    initial
    begin
        int gap;
        bit calm;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.match_tx(tx_byte, run_last);
        end
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] directed [] = '{8'hFF, 8'h01, 8'h7F, 8'h80,
                                    slebc_pkg::CH_CR, slebc_pkg::CH_LF,
                                    8'h41, slebc_pkg::CH_NUL, 8'h42, slebc_pkg::CH_CR,
                                    slebc_pkg::CH_NUL, slebc_pkg::CH_LF,
                                    8'h0C, 8'h0E, 8'h09, 8'h0B, 8'hAA, 8'h55,
                                    slebc_pkg::CH_LF};
        int         n;
        int         k;
        int         sel;
        bit         calm;
        logic [7:0] c;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i], 1'b0);

        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    n = $urandom_range(0, 12);
                else if (sel < 9)
                    n = $urandom_range(13, 30);
                else
                    n = $urandom_range(31, 45);
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        c = slebc_pkg::CH_NUL;
                    else
                        do
                            c = 8'($urandom_range(1, 255));
                        while (c == slebc_pkg::CH_CR || c == slebc_pkg::CH_LF);
                    send_byte(c, calm);
                end
                send_byte($urandom_range(0, 1) ? slebc_pkg::CH_CR : slebc_pkg::CH_LF, calm);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    send_byte(8'($urandom_range(0, 255)), calm);
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
